// File: hw/rtl/rgb2yuv_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rgb2yuv_pkg
// Shared types, register indexes and the BT.601 coefficient ROM tables.
// ---------------------------------------------------------------------------
package rgb2yuv_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

  localparam logic KIND_LUMA   = 1'b0;
  localparam logic KIND_CHROMA = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  // coefficient selectors for the ROM builder
  localparam int unsigned COEF_YR   = 0;
  localparam int unsigned COEF_YG   = 1;
  localparam int unsigned COEF_YB   = 2;
  localparam int unsigned COEF_UR   = 3;
  localparam int unsigned COEF_UG   = 4;
  localparam int unsigned COEF_VG   = 5;
  localparam int unsigned COEF_VB   = 6;
  localparam int unsigned COEF_K112 = 7;

  localparam logic [25:0]        LUMA_OFFSET   = 26'd1048576;
  localparam logic signed [26:0] CHROMA_OFFSET = 27'sd8388608;

  typedef logic [23:0] rom_word_t;
  typedef rom_word_t rom_t [256];

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic odd_col;
    logic odd_row;
    logic last_block;
  } pix_class_t;

  // trunc(float(coef) * float(i << 8)); mantissa and exponent of each
  // single-precision coefficient are given directly
  function automatic rom_word_t rom_value(input int unsigned c, input int unsigned i);
    logic [47:0] q;
    int unsigned k;
    int unsigned s;
    int unsigned j;
    logic [47:0] p;
    logic [47:0] r;
    logic [47:0] low;
    logic [47:0] half;
    case (c)
      COEF_YR:   begin q = 48'd8582726;  k = 17; end
      COEF_YG:   begin q = 48'd8424849;  k = 16; end
      COEF_YB:   begin q = 48'd13089374; k = 19; end
      COEF_UR:   begin q = 48'd9908257;  k = 18; end
      COEF_UG:   begin q = 48'd9725936;  k = 17; end
      COEF_VG:   begin q = 48'd12292719; k = 17; end
      COEF_VB:   begin q = 48'd9549382;  k = 19; end
      default:   begin q = 48'd14680064; k = 17; end
    endcase
    p = q * (48'(i & 32'hFF) << 8);
    if (p == 48'd0) begin
      return 24'd0;
    end
    s = 0;
    for (j = 0; j < 24; j++) begin
      if ((p >> s) >= 48'h1000000) begin
        s = s + 1;
      end
    end
    r = p >> s;
    if (s > 0) begin
      low  = p & ((48'd1 << s) - 48'd1);
      half = 48'd1 << (s - 1);
      if (low > half || (low == half && r[0])) begin
        r = r + 48'd1;
      end
      if (r >= 48'h1000000) begin
        r = r >> 1;
        s = s + 1;
      end
    end
    if (s >= k) begin
      return 24'(r << (s - k));
    end
    return 24'(r >> (k - s));
  endfunction

  function automatic rom_t build_rom(input int unsigned c);
    rom_t t;
    int unsigned i;
    for (i = 0; i < 256; i++) begin
      t[i] = rom_value(c, i);
    end
    return t;
  endfunction

  localparam rom_t ROM_YR   = build_rom(COEF_YR);
  localparam rom_t ROM_YG   = build_rom(COEF_YG);
  localparam rom_t ROM_YB   = build_rom(COEF_YB);
  localparam rom_t ROM_UR   = build_rom(COEF_UR);
  localparam rom_t ROM_UG   = build_rom(COEF_UG);
  localparam rom_t ROM_VG   = build_rom(COEF_VG);
  localparam rom_t ROM_VB   = build_rom(COEF_VB);
  localparam rom_t ROM_K112 = build_rom(COEF_K112);

endpackage
`default_nettype wire

// File: hw/rtl/rgb2yuv_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rgb2yuv channel interfaces
// Pixel input, result output and configuration write channels.
// ---------------------------------------------------------------------------
interface rgb2yuv_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_value;
  logic [7:0] green_value;
  logic [7:0] blue_value;

  modport source (output valid, red_value, green_value, blue_value, input ready);
  modport sink   (input valid, red_value, green_value, blue_value, output ready);
endinterface

interface rgb2yuv_res_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] luma_out;
  logic [7:0] cb_out;
  logic [7:0] cr_out;
  logic       run_last;
  logic       frame_done;

  modport source (output valid, item_kind, luma_out, cb_out, cr_out, run_last, frame_done,
                  input ready);
  modport sink   (input valid, item_kind, luma_out, cb_out, cr_out, run_last, frame_done,
                  output ready);
endinterface

interface rgb2yuv_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rgb2yuv_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rgb2yuv_queue
// Small FIFO between the classifying front end and the colour back end.
// ---------------------------------------------------------------------------
module rgb2yuv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;
  logic             push;
  logic             pop;

  assign push_ready = (fill != NW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = store[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + NW'(1);
      end else if (pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rgb2yuv_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rgb2yuv_front
// Frame size registers, raster counters and per-pixel classification.
// ---------------------------------------------------------------------------
module rgb2yuv_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int IW         = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  rgb2yuv_pix_if.sink               pix,
  rgb2yuv_cfg_if.sink               cfg,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output rgb2yuv_pkg::pix_class_t   cls,
  output logic [IW-1:0]             idx,
  output rgb2yuv_pkg::rgb_t         rgb
);
  import rgb2yuv_pkg::*;

  localparam int CCW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RCW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int W_LIMIT = MAX_WIDTH - (MAX_WIDTH % 2);
  localparam int H_LIMIT = MAX_HEIGHT - (MAX_HEIGHT % 2);

  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic [CCW-1:0]        column_count;
  logic [RCW-1:0]        row_count;
  logic [CCW-1:0]        column_count_next;
  logic [RCW-1:0]        row_count_next;

  logic [CFG_DATA_W-1:0] w_even;
  logic [CFG_DATA_W-1:0] h_even;
  logic [CCW:0]          w_eff;
  logic [RCW:0]          h_eff;
  logic                  wrap_col;
  logic [CCW-1:0]        col_e;
  logic [RCW:0]          row_p;
  logic [RCW-1:0]        row_e;
  logic [CCW:0]          col_inc;
  logic [RCW:0]          row_inc;
  logic                  end_row;
  logic                  end_frame;
  logic                  accept;

  assign cfg.ready  = 1'b1;
  assign push_valid = pix.valid;
  assign pix.ready  = push_ready;
  assign accept     = pix.valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data;
        REG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective sizes: low bit dropped, clamped to [2, max]
  always_comb begin
    w_even = {frame_width[CFG_DATA_W-1:1], 1'b0};
    h_even = {frame_height[CFG_DATA_W-1:1], 1'b0};
    if (w_even < 12'd2) begin
      w_eff = (CCW+1)'(2);
    end else if (int'(w_even) > W_LIMIT) begin
      w_eff = (CCW+1)'(W_LIMIT);
    end else begin
      w_eff = (CCW+1)'(w_even);
    end
    if (h_even < 12'd2) begin
      h_eff = (RCW+1)'(2);
    end else if (int'(h_even) > H_LIMIT) begin
      h_eff = (RCW+1)'(H_LIMIT);
    end else begin
      h_eff = (RCW+1)'(h_even);
    end
  end

  always_comb begin
    // a size change mid-frame can leave the counters out of range: wrap them
    wrap_col  = {1'b0, column_count} >= w_eff;
    col_e     = wrap_col ? '0 : column_count;
    row_p     = wrap_col ? {1'b0, row_count} + (RCW+1)'(1) : {1'b0, row_count};
    row_e     = (row_p >= h_eff) ? '0 : row_p[RCW-1:0];
    col_inc   = {1'b0, col_e} + (CCW+1)'(1);
    row_inc   = {1'b0, row_e} + (RCW+1)'(1);
    end_row   = col_inc >= w_eff;
    end_frame = row_inc >= h_eff;
    if (end_row) begin
      column_count_next = '0;
      row_count_next    = end_frame ? '0 : row_inc[RCW-1:0];
    end else begin
      column_count_next = col_inc[CCW-1:0];
      row_count_next    = row_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  assign cls.odd_col    = col_e[0];
  assign cls.odd_row    = row_e[0];
  assign cls.last_block = end_row && end_frame;
  assign idx            = IW'(col_e >> 1);
  assign rgb.red        = pix.red_value;
  assign rgb.green      = pix.green_value;
  assign rgb.blue       = pix.blue_value;

endmodule
`default_nettype wire

// File: hw/rtl/rgb2yuv_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rgb2yuv_back
// ROM lookup, Y/U/V sums, 2x2 chroma averaging with line store, result
// register.
// ---------------------------------------------------------------------------
module rgb2yuv_back #(
  parameter int MAX_WIDTH = 2048,
  parameter int IW        = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     pop_valid,
  output logic                          pop_ready,
  input  wire rgb2yuv_pkg::pix_class_t  cls,
  input  wire logic [IW-1:0]            idx,
  input  wire rgb2yuv_pkg::rgb_t        rgb,
  rgb2yuv_res_if.source                 res
);
  import rgb2yuv_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;

  // stage A: ROM terms
  logic       a_valid;
  pix_class_t a_cls;
  logic [IW-1:0] a_idx;
  rom_word_t  a_yr, a_yg, a_yb;
  rom_word_t  a_ur, a_ug, a_ub;
  rom_word_t  a_vr, a_vg, a_vb;

  // stage B: per-pixel Y/U/V
  logic       b_valid;
  pix_class_t b_cls;
  logic [IW-1:0] b_idx;
  logic [7:0] b_y, b_u, b_v;

  // stage C: pair sums and top row read
  logic       c_valid;
  logic       c_chroma;
  logic       c_last;
  logic [7:0] c_y;
  logic [8:0] c_su, c_sv;
  logic [17:0] top_rd;
  logic       phase;

  logic [7:0] left_u, left_v;
  logic [17:0] line_store [LINE_DEPTH];

  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_luma, out_cb, out_cr;
  logic       out_last, out_done;

  logic [25:0]        y_sum;
  logic signed [26:0] u_t, v_t;
  logic [7:0]         y_val, u_val, v_val;
  logic [8:0]         su, sv;
  logic [9:0]         cb_sum, cr_sum;

  logic out_free, out_load, c_done, c_take, b_take, a_take, b_fire;

  assign out_free  = !out_valid || res.ready;
  assign out_load  = c_valid && out_free;
  assign c_done    = out_load && (phase || !c_chroma);
  assign c_take    = !c_valid || c_done;
  assign b_take    = !b_valid || c_take;
  assign a_take    = !a_valid || b_take;
  assign pop_ready = a_take;
  assign b_fire    = b_valid && c_take;

  always_ff @(posedge clk) begin
    if (a_take) begin
      a_cls <= cls;
      a_idx <= idx;
      a_yr  <= ROM_YR[rgb.red];
      a_yg  <= ROM_YG[rgb.green];
      a_yb  <= ROM_YB[rgb.blue];
      a_ur  <= ROM_UR[rgb.red];
      a_ug  <= ROM_UG[rgb.green];
      a_ub  <= ROM_K112[rgb.blue];
      a_vr  <= ROM_K112[rgb.red];
      a_vg  <= ROM_VG[rgb.green];
      a_vb  <= ROM_VB[rgb.blue];
    end
  end

  always_comb begin
    y_sum = 26'(a_yr) + 26'(a_yg) + 26'(a_yb) + LUMA_OFFSET;
    u_t   = CHROMA_OFFSET + $signed({3'b0, a_ub}) - $signed({3'b0, a_ur})
            - $signed({3'b0, a_ug});
    v_t   = CHROMA_OFFSET + $signed({3'b0, a_vr}) - $signed({3'b0, a_vg})
            - $signed({3'b0, a_vb});
    y_val = y_sum[23:16];
    u_val = u_t[26] ? 8'd0 : u_t[23:16];
    v_val = v_t[26] ? 8'd0 : v_t[23:16];
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      b_cls <= a_cls;
      b_idx <= a_idx;
      b_y   <= y_val;
      b_u   <= u_val;
      b_v   <= v_val;
    end
  end

  assign su = {1'b0, left_u} + {1'b0, b_u};
  assign sv = {1'b0, left_v} + {1'b0, b_v};

  // top row writes its pair sum, bottom row reads it back
  always_ff @(posedge clk) begin
    if (b_fire && b_cls.odd_col && !b_cls.odd_row) begin
      line_store[b_idx] <= {su, sv};
    end
    if (b_fire && b_cls.odd_col && b_cls.odd_row) begin
      top_rd <= line_store[b_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_u <= '0;
      left_v <= '0;
    end else if (b_fire && !b_cls.odd_col) begin
      left_u <= b_u;
      left_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (c_take) begin
      c_y      <= b_y;
      c_su     <= su;
      c_sv     <= sv;
      c_chroma <= b_cls.odd_col && b_cls.odd_row;
      c_last   <= b_cls.last_block;
    end
  end

  assign cb_sum = 10'(top_rd[17:9]) + 10'(c_su);
  assign cr_sum = 10'(top_rd[8:0]) + 10'(c_sv);

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (!phase) begin
        out_kind <= KIND_LUMA;
        out_luma <= c_y;
        out_cb   <= 8'd0;
        out_cr   <= 8'd0;
        out_last <= !c_chroma;
        out_done <= 1'b0;
      end else begin
        out_kind <= KIND_CHROMA;
        out_luma <= 8'd0;
        out_cb   <= cb_sum[9:2];
        out_cr   <= cr_sum[9:2];
        out_last <= 1'b1;
        out_done <= c_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_take) begin
        a_valid <= pop_valid;
      end
      if (b_take) begin
        b_valid <= a_valid;
      end
      if (c_take) begin
        c_valid <= b_valid;
      end
      // hold the block for its chroma transaction after the luma one
      if (out_load) begin
        phase <= !phase && c_chroma;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid      = out_valid;
  assign res.item_kind  = out_kind;
  assign res.luma_out   = out_luma;
  assign res.cb_out     = out_cb;
  assign res.cr_out     = out_cr;
  assign res.run_last   = out_last;
  assign res.frame_done = out_done;

endmodule
`default_nettype wire

// File: hw/rtl/rgb_to_yuv420_converter.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rgb_to_yuv420_converter
// RGB to BT.601 YCbCr with 4:2:0 chroma averaging over 2x2 blocks.
// ---------------------------------------------------------------------------
// Pixels enter in raster order, one transaction per pixel. Each pixel gives
// a luma transaction; the bottom-right pixel of every 2x2 block gives a
// second, chroma transaction right after it, holding the truncated mean of
// the block's four Cb and four Cr values. The front end takes one pixel per
// cycle while the queue has room; the single result register passes one
// transaction per cycle while results are taken, so a bottom-row pixel
// pair gives three transactions against two for a top-row pair. A pixel's
// luma result passes through the queue, the ROM, sum and pair stages, then
// the result register. The line store of top-row pair sums has no reset
// and needs no clearing pass: each entry is written on a top row before the
// bottom row reads it. Write the frame size only while the block is idle.
module rgb_to_yuv420_converter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic     clk,
  input  wire logic     rst,
  rgb2yuv_pix_if.sink   pix,
  rgb2yuv_cfg_if.sink   cfg,
  rgb2yuv_res_if.source res
);
  import rgb2yuv_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int IW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int QW = $bits(pix_class_t) + IW + $bits(rgb_t);

  logic          push_valid, push_ready;
  logic          pop_valid, pop_ready;
  pix_class_t    f_cls, q_cls;
  logic [IW-1:0] f_idx, q_idx;
  rgb_t          f_rgb, q_rgb;
  logic [QW-1:0] push_data, pop_data;

  rgb2yuv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .IW         (IW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .cls        (f_cls),
    .idx        (f_idx),
    .rgb        (f_rgb)
  );

  assign push_data = {f_cls, f_idx, f_rgb};

  rgb2yuv_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {q_cls, q_idx, q_rgb} = pop_data;

  rgb2yuv_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .IW        (IW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .cls       (q_cls),
    .idx       (q_idx),
    .rgb       (q_rgb),
    .res       (res)
  );

endmodule
`default_nettype wire
